/* hw/rtl/ddo_pkg.sv */
// Shared constants, types and the arctangent table for the odometry update block.
package ddo_pkg;

  localparam int unsigned TRIG_STEPS_DEF = 16;
  localparam int unsigned ATAN_ENTRIES   = 24;
  localparam int unsigned MUL_W          = 33;

  localparam logic [15:0] DPP_RESET    = 16'd25613;
  localparam logic [14:0] FULL_TURN    = 15'd23040;
  localparam logic [14:0] QUARTER_TURN = 15'd5760;
  localparam logic [14:0] HALF_TURN    = 15'd11520;
  localparam logic [14:0] THREE_QTR    = 15'd17280;

  // pi in Q2.30 split as 11520 * PI_QUOT + PI_REM
  localparam logic [18:0] PI_QUOT      = 19'd292817;
  localparam logic [12:0] PI_REM       = 13'd7586;
  localparam logic [25:0] ROUND_HALF   = 26'd5760;
  // floor(u/45) = (u * RECIP45) >> 24 for u < 2^18
  localparam logic [18:0] RECIP45      = 19'd372828;
  // floor(t/5) = (t * RECIP5) >> 34 for t < 2^32
  localparam logic [31:0] RECIP5       = 32'hCCCCCCCD;

  localparam logic [31:0] CORDIC_GAIN  = 32'h26DD3B6A;

  typedef struct packed {
    logic        start;
    logic [32:0] z0;
  } cordic_ctrl_t;

  typedef struct packed {
    logic done;
  } cordic_stat_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/ddo_mul.sv */
// Shared signed multiplier with registered product.
module ddo_mul #(
  parameter int unsigned W = ddo_pkg::MUL_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

/* hw/rtl/ddo_cordic.sv */
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
module ddo_cordic #(
  parameter int unsigned TRIG_STEPS = ddo_pkg::TRIG_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ddo_pkg::cordic_ctrl_t ctrl,
  output ddo_pkg::cordic_stat_t stat,
  output logic signed [31:0]   cos_q30,
  output logic signed [31:0]   sin_q30
);

  localparam int unsigned IW = (TRIG_STEPS > 1) ? $clog2(TRIG_STEPS) : 1;

  logic signed [31:0] x, y;
  logic signed [32:0] z;
  logic [IW-1:0]      cnt;
  logic               run;
  logic               done;

  logic signed [31:0] xs, ys;
  logic signed [32:0] ang;

  assign xs  = x >>> cnt;
  assign ys  = y >>> cnt;
  assign ang = $signed({3'b000, ddo_pkg::atan_q30(5'(cnt))});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        x   <= $signed(ddo_pkg::CORDIC_GAIN);
        y   <= '0;
        z   <= ctrl.z0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (!z[32]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ang;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ang;
        end
        if (cnt == IW'(TRIG_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign cos_q30   = x;
  assign sin_q30   = y;

endmodule

/* hw/rtl/diff_drive_odometry_update.sv */
// Top level: sequencer for the dead-reckoning position update.
//
//  channel  | dir | width | contents
//  ---------+-----+-------+--------------------------------------------------
//  s_axis   | in  | 48    | left_pulses, right_pulses, heading
//  m_axis   | out | 64    | pos_x, pos_y (saturating Q16.16 cm)
//  cfg      | in  | 16    | dist_per_pulse (Q0.16 mm)
//
// Each item takes seven passes through the shared multiplier plus TRIG_STEPS CORDIC
// iterations, one per cycle.
// s_axis_tready is high only while the sequencer is idle.
// A result waits in the position registers; the next item is taken meanwhile and
// stalls in its final step until that result has been transferred.
// Reset (synchronous) clears both positions and loads the default dist_per_pulse.
module diff_drive_odometry_update #(
  parameter int unsigned TRIG_STEPS = ddo_pkg::TRIG_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // [15:0] left_pulses, [31:16] right_pulses,
                                     // [46:32] heading, [47] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [31:0] pos_x, [63:32] pos_y
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned MW = ddo_pkg::MUL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_M_PROD, S_M_RECIP, S_M_RR, S_M_U, S_M_RQ,
    S_Z_LOAD, S_ROT, S_M_X, S_M_Y, S_ACC
  } state_t;

  state_t state;

  logic [15:0]        dist_per_pulse;
  logic signed [31:0] x_position, y_position;
  logic               out_valid;

  logic signed [16:0] sum_lr;
  logic [1:0]         quad;
  logic [12:0]        resid;
  logic               neg;
  logic signed [28:0] d;
  logic [11:0]        uq;
  logic signed [31:0] c_val, s_val;
  logic signed [33:0] dx;

  // multiplier
  logic                   mul_en;
  logic signed [MW-1:0]   op_a, op_b;
  logic signed [2*MW-1:0] p;

  ddo_mul #(.W(MW)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (op_a),
    .b   (op_b),
    .p   (p)
  );

  // CORDIC
  ddo_pkg::cordic_ctrl_t cctrl;
  ddo_pkg::cordic_stat_t cstat;
  logic signed [31:0]    cos_q30, sin_q30;

  ddo_cordic #(.TRIG_STEPS(TRIG_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cctrl),
    .stat    (cstat),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  assign cctrl.start = (state == S_Z_LOAD);
  assign cctrl.z0    = $signed({1'b0, p[31:0]}) + $signed({21'd0, uq});

  // heading -> angle (360 - heading), quadrant and residual
  logic [14:0] hdg, h, a;
  logic [1:0]  quad_in;
  logic [14:0] resid_w;

  always_comb begin
    hdg = s_axis_tdata[46:32];
    h   = (hdg >= ddo_pkg::FULL_TURN) ? hdg - ddo_pkg::FULL_TURN : hdg;
    a   = (h == '0) ? '0 : ddo_pkg::FULL_TURN - h;
    if (a >= ddo_pkg::THREE_QTR) begin
      quad_in = 2'd3;
      resid_w = a - ddo_pkg::THREE_QTR;
    end else if (a >= ddo_pkg::HALF_TURN) begin
      quad_in = 2'd2;
      resid_w = a - ddo_pkg::HALF_TURN;
    end else if (a >= ddo_pkg::QUARTER_TURN) begin
      quad_in = 2'd1;
      resid_w = a - ddo_pkg::QUARTER_TURN;
    end else begin
      quad_in = 2'd0;
      resid_w = a;
    end
  end

  // magnitude of the scaled count, biased for round half up before /20
  logic signed [32:0] prod;
  logic [32:0]        mag;
  logic [32:0]        mag_b;
  assign prod  = p[32:0];
  assign mag   = prod[32] ? 33'(-prod) : 33'(prod);
  assign mag_b = mag + 33'd10;

  logic [27:0] q;
  assign q = p[61:34];

  logic [25:0] w_rem;
  assign w_rem = p[25:0] + ddo_pkg::ROUND_HALF;

  // final rounding of a component: floor((d*trig + 2^29) / 2^30)
  logic signed [2*MW-1:0] p_rnd;
  assign p_rnd = p + (2*MW)'(64'd1 << 29);

  always_comb begin
    mul_en = 1'b0;
    op_a   = '0;
    op_b   = '0;
    case (state)
      S_M_PROD: begin
        mul_en = 1'b1;
        op_a   = MW'(sum_lr);
        op_b   = $signed({17'd0, dist_per_pulse});
      end
      S_M_RECIP: begin
        mul_en = 1'b1;
        op_a   = $signed({3'd0, mag_b[31:2]});
        op_b   = $signed({1'b0, ddo_pkg::RECIP5});
      end
      S_M_RR: begin
        mul_en = 1'b1;
        op_a   = $signed({20'd0, resid});
        op_b   = $signed({20'd0, ddo_pkg::PI_REM});
      end
      S_M_U: begin
        mul_en = 1'b1;
        op_a   = $signed({15'd0, w_rem[25:8]});
        op_b   = $signed({14'd0, ddo_pkg::RECIP45});
      end
      S_M_RQ: begin
        mul_en = 1'b1;
        op_a   = $signed({20'd0, resid});
        op_b   = $signed({14'd0, ddo_pkg::PI_QUOT});
      end
      S_M_X: begin
        mul_en = 1'b1;
        op_a   = MW'(d);
        op_b   = MW'(c_val);
      end
      S_M_Y: begin
        mul_en = 1'b1;
        op_a   = MW'(d);
        op_b   = MW'(s_val);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // saturating accumulate
  logic signed [33:0] dy;
  logic signed [33:0] x_sum, y_sum;
  logic signed [31:0] x_next, y_next;

  assign dy    = p_rnd[63:30];
  assign x_sum = 34'(x_position) + dx;
  assign y_sum = 34'(y_position) + dy;

  always_comb begin
    if (x_sum[33:31] == 3'b000 || x_sum[33:31] == 3'b111) begin
      x_next = x_sum[31:0];
    end else begin
      x_next = x_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if (y_sum[33:31] == 3'b000 || y_sum[33:31] == 3'b111) begin
      y_next = y_sum[31:0];
    end else begin
      y_next = y_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      dist_per_pulse <= ddo_pkg::DPP_RESET;
      x_position     <= '0;
      y_position     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        dist_per_pulse <= cfg_wdata;
      end
      // in S_ACC the accumulate step below owns out_valid
      if (out_valid && m_axis_tready && state != S_ACC) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sum_lr <= 17'($signed(s_axis_tdata[15:0])) + 17'($signed(s_axis_tdata[31:16]));
            quad   <= quad_in;
            resid  <= resid_w[12:0];
            state  <= S_M_PROD;
          end
        end
        S_M_PROD: begin
          state <= S_M_RECIP;
        end
        S_M_RECIP: begin
          neg   <= prod[32];
          state <= S_M_RR;
        end
        S_M_RR: begin
          d     <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
          state <= S_M_U;
        end
        S_M_U: begin
          state <= S_M_RQ;
        end
        S_M_RQ: begin
          uq    <= p[35:24];
          state <= S_Z_LOAD;
        end
        S_Z_LOAD: begin
          state <= S_ROT;
        end
        S_ROT: begin
          if (cstat.done) begin
            case (quad)
              2'd0: begin
                c_val <= cos_q30;
                s_val <= sin_q30;
              end
              2'd1: begin
                c_val <= -sin_q30;
                s_val <= cos_q30;
              end
              2'd2: begin
                c_val <= -cos_q30;
                s_val <= -sin_q30;
              end
              default: begin
                c_val <= sin_q30;
                s_val <= -cos_q30;
              end
            endcase
            state <= S_M_X;
          end
        end
        S_M_X: begin
          state <= S_M_Y;
        end
        S_M_Y: begin
          dx    <= p_rnd[63:30];
          state <= S_ACC;
        end
        S_ACC: begin
          if (!out_valid || m_axis_tready) begin
            x_position <= x_next;
            y_position <= y_next;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {y_position, x_position};

endmodule

/* hw/rtl/ddo_checker.sv */
// Port-level checker for the odometry update block, bound to the top level.
module ddo_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // one item at a time: ready drops right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("s_axis_tready stayed high after an input transfer");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed or dropped while stalled");

  // a new result only appears at the end of an item's work
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item in progress");

  // reset leaves no pending result and an idle input side
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("block not idle after reset");

endmodule

bind diff_drive_odometry_update ddo_checker u_ddo_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb_diff_drive_odometry_update.sv */
// Self-checking testbench for the differential-drive odometry update block.
module tb_diff_drive_odometry_update;

  localparam int unsigned STEPS       = ddo_pkg::TRIG_STEPS_DEF;
  localparam int unsigned ATAN_LEN    = 24;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          RUN_LEN     = 12;

  // packed so that the struct lines up with tdata[46:0]
  typedef struct packed {
    logic [14:0]        heading;
    logic signed [15:0] right;
    logic signed [15:0] left;
  } odo_step_t;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
  } pose_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  diff_drive_odometry_update dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // tracked copy of the block state
  logic [15:0] dpp_now = ddo_pkg::DPP_RESET;
  longint      trk_x = 0;
  longint      trk_y = 0;

  odo_step_t step_q[$];
  pose_t     pose_q[$];
  odo_step_t on_bus;
  pose_t     want;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        n_errors = 0;
  int        quiet = 0;

  // arctangent of 2^-i, Q2.30, truncated
  function automatic longint atan_step(input int i);
    case (i)
      0:  return 64'h3243F6A8;
      1:  return 64'h1DAC6705;
      2:  return 64'h0FADBAFC;
      3:  return 64'h07F56EA6;
      4:  return 64'h03FEAB76;
      5:  return 64'h01FFD55B;
      6:  return 64'h00FFFAAA;
      7:  return 64'h007FFF55;
      8:  return 64'h003FFFEA;
      9:  return 64'h001FFFFD;
      10: return 64'h000FFFFF;
      11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;
      13: return 64'h0001FFFF;
      14: return 64'h0000FFFF;
      15: return 64'h00007FFF;
      16: return 64'h00003FFF;
      17: return 64'h00001FFF;
      18: return 64'h00000FFF;
      19: return 64'h000007FF;
      20: return 64'h000003FF;
      21: return 64'h000001FF;
      22: return 64'h000000FF;
      default: return 64'h0000007F;
    endcase
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // cos/sin in Q2.30 of a residual angle (1/64 degree, below a quarter turn)
  function automatic void unit_vector(input int unsigned resid, output longint c,
                                      output longint s);
    longint z, x, y, xs, ys;
    z = (longint'(resid) * 64'sd3373259426 + 64'sd5760) / 64'sd11520;
    x = longint'(ddo_pkg::CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end
    end
    c = x;
    s = y;
  endfunction

  // advances the tracked position by one interval and returns the new pose
  function automatic pose_t next_pose(input odo_step_t st);
    longint      prod, mag, q, d, c0, s0, c, s, dx, dy;
    int unsigned h, a, quad;
    pose_t       p;
    prod = (longint'(st.left) + longint'(st.right)) * longint'(dpp_now);
    mag = (prod < 0) ? -prod : prod;
    q = (mag + 10) / 20;
    d = (prod < 0) ? -q : q;
    h = int'(st.heading) % int'(ddo_pkg::FULL_TURN);
    a = (h == 0) ? 0 : int'(ddo_pkg::FULL_TURN) - h;
    quad = a / int'(ddo_pkg::QUARTER_TURN);
    unit_vector(a % int'(ddo_pkg::QUARTER_TURN), c0, s0);
    case (quad)
      0: begin
        c = c0;
        s = s0;
      end
      1: begin
        c = -s0;
        s = c0;
      end
      2: begin
        c = -c0;
        s = -s0;
      end
      default: begin
        c = s0;
        s = -c0;
      end
    endcase
    dx = (d * c + (longint'(1) <<< 29)) >>> 30;
    dy = (d * s + (longint'(1) <<< 29)) >>> 30;
    trk_x = clamp32(trk_x + dx);
    trk_y = clamp32(trk_y + dy);
    p.pos_x = trk_x[31:0];
    p.pos_y = trk_y[31:0];
    return p;
  endfunction

  function automatic logic signed [15:0] rand_pulses();
    int unsigned k;
    int          v;
    k = $urandom_range(99);
    if (k < 60) begin
      v = int'($urandom_range(2048)) - 1024;
      return v[15:0];
    end
    if (k < 85) return 16'($urandom);
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'hFFFF;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic odo_step_t random_step();
    odo_step_t   st;
    int unsigned k;
    st.left = rand_pulses();
    // spin in place now and then: no travel, unless left is the most negative count
    st.right = ($urandom_range(99) < 10) ? -st.left : rand_pulses();
    k = $urandom_range(99);
    if (k < 82)
      st.heading = 15'($urandom_range(ddo_pkg::FULL_TURN));
    else if (k < 94)
      st.heading = 15'(ddo_pkg::QUARTER_TURN * $urandom_range(4))
                   + 15'($urandom_range(2)) - 15'd1;
    else
      st.heading = 15'($urandom_range(32767));
    return st;
  endfunction

  task automatic push_step(input logic signed [15:0] l, input logic signed [15:0] r,
                           input logic [14:0] h);
    odo_step_t st;
    st.left = l;
    st.right = r;
    st.heading = h;
    step_q.push_back(st);
  endtask

  // full-speed run on one heading: drives a coordinate into saturation
  task automatic push_run(input logic signed [15:0] p, input logic [14:0] h);
    for (int i = 0; i < RUN_LEN; i++) push_step(p, p, h);
  endtask

  task automatic wait_idle();
    while (step_q.size() != 0 || s_axis_tvalid || pose_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_dpp(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dpp_now = v;
  endtask

  task automatic run_phase(input logic [15:0] dpp, input int send_pct, input int recv_pct,
                           input int n);
    int pushed;
    write_dpp(dpp);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(99) < 3) begin
        push_run($urandom_range(1) ? 16'sh7FFF : 16'sh8000,
                 15'(ddo_pkg::QUARTER_TURN * $urandom_range(3)));
        pushed += RUN_LEN;
      end else begin
        step_q.push_back(random_step());
        pushed++;
      end
    end
    wait_idle();
  endtask

  // input side: one transfer per accepted step, prediction made on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) pose_q.push_back(next_pose(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (step_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = step_q.pop_front();
          s_axis_tdata <= {1'b0, on_bus};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pose_q.size() == 0) begin
          $display("%0t: result with nothing expected: got %h", $time, m_axis_tdata);
          n_errors++;
        end else begin
          want = pose_q.pop_front();
          if (m_axis_tdata[31:0] !== want.pos_x) begin
            $display("%0t: pos_x expected %h got %h", $time, want.pos_x, m_axis_tdata[31:0]);
            n_errors++;
          end
          if (m_axis_tdata[63:32] !== want.pos_y) begin
            $display("%0t: pos_y expected %h got %h", $time, want.pos_y,
                     m_axis_tdata[63:32]);
            n_errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles without any transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("[diff_drive_odometry_update] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, each quadrant, heading wrap, then saturation runs
    write_dpp(16'hFFFF);
    send_idle_pct = 27;
    recv_stall_pct = 61;
    push_step(16'sd0, 16'sd0, 15'd0);
    push_step(16'sh7FFF, 16'sh7FFF, 15'd0);
    push_step(16'sh8000, 16'sh8000, 15'd0);
    push_step(16'sd100, 16'sd100, ddo_pkg::QUARTER_TURN);
    push_step(16'sd100, 16'sd100, ddo_pkg::HALF_TURN);
    push_step(16'sd100, 16'sd100, ddo_pkg::THREE_QTR);
    push_step(16'sd100, 16'sd100, ddo_pkg::FULL_TURN);
    push_step(16'sd100, 16'sd100, ddo_pkg::FULL_TURN + 15'd1);
    push_step(16'sd100, 16'sd100, 15'h7FFF);
    push_step(16'sh7FFF, 16'sh8000, 15'd1234);
    push_step(16'sd1, 16'sd0, 15'd1);
    push_step(-16'sd1, 16'sd0, ddo_pkg::QUARTER_TURN - 15'd1);
    push_step(-16'sd300, 16'sd500, ddo_pkg::QUARTER_TURN + 15'd1);
    push_run(16'sh7FFF, 15'd0);
    push_run(16'sh8000, ddo_pkg::THREE_QTR);
    wait_idle();

    run_phase(16'h0000, 27, 61, 150);
    run_phase(16'h0001, 27, 61, 150);
    run_phase(16'($urandom), 61, 27, 500);
    run_phase(ddo_pkg::DPP_RESET, 61, 27, 400);
    run_phase(16'($urandom), 0, 0, 400);
    run_phase(16'hFFFF, 0, 0, 250);

    repeat (20) @(posedge clk);
    if (n_errors == 0)
      $display("[diff_drive_odometry_update] OK");
    else
      $display("[diff_drive_odometry_update] ERROR");
    $finish;
  end

endmodule

/* diff_drive_odometry_update.f */
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_mul.sv
hw/rtl/ddo_cordic.sv
hw/rtl/diff_drive_odometry_update.sv
hw/rtl/ddo_checker.sv
dv/tb_diff_drive_odometry_update.sv
